[hdl/llh_pkg.sv]
// Package for the log2 latency histogram: sizes, command and status codes,
// and the controller state type. No dependencies.
`timescale 1ns / 1ps
package llh_pkg;

  localparam int THREAD_SLOTS = 64;
  localparam int BUCKETS      = 64;
  localparam int HISTOGRAMS   = 8;
  localparam int COUNT_BITS   = 32;

  localparam int SLOT_AW   = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int BUCKET_W  = $clog2(BUCKETS);
  localparam int CNT_DEPTH = HISTOGRAMS * BUCKETS;
  localparam int CNT_AW    = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
  localparam int TS_W      = 63;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_START   = 2'd0,
    ST_COUNTED = 2'd1,
    ST_IGNORED = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIFF,
    S_LZ1,
    S_LZ2,
    S_UPD,
    S_RESULT
  } state_t;

endpackage

[hdl/latency_log2_histogram_top.sv]
// Top level of the log2 latency histogram: start-time memory, slot valid
// bits, bucket count memory and the command sequencer. Uses llh_pkg, llh_log2.
`timescale 1ns / 1ps
// After reset the block sweeps the count memory to zero, one entry a cycle,
// through all HISTOGRAMS*BUCKETS (512) entries with in_ready low. It then
// works on one word at a time: a start, a read or an ignored end goes from
// acceptance to the result register; an end that is counted passes through
// start-time memory read, 64-bit subtract, first log2 encoder stage, second
// stage with the count memory read, increment and write-back; an unused
// command is accepted and dropped with no result. The result register lets
// the next word be accepted while a result still waits for out_ready.
module latency_log2_histogram_top
  import llh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [5:0]  thread_slot,
  input  logic [62:0] timestamp,
  input  logic [2:0]  hist_select,
  input  logic [5:0]  bucket_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  bucket,
  output logic [31:0] count
);

  state_t state, state_next;

  logic [TS_W-1:0]       st_mem [THREAD_SLOTS];
  logic [TS_W-1:0]       st_rd;
  logic [THREAD_SLOTS-1:0] start_valid;
  logic [COUNT_BITS-1:0] cnt_mem [CNT_DEPTH];
  logic [COUNT_BITS-1:0] cnt_rd;

  logic [CNT_AW-1:0]     clr_addr;
  logic                  clr_done;

  logic                  accept;
  logic [SLOT_AW-1:0]    slot_idx;
  logic                  slot_ok, hist_ok, bidx_ok, valid_hit;
  cmd_t                  cmd_in;

  logic [TS_W-1:0]       ts_q;
  logic [2:0]            hist_q;
  status_t               res_status;
  logic [5:0]            res_bucket;
  logic                  res_use_cnt;
  logic [63:0]           diff_q;
  logic [BUCKET_W-1:0]   lg_bucket;
  logic [BUCKET_W-1:0]   bucket_q;
  logic [CNT_AW-1:0]     upd_addr;

  logic                  out_free;
  logic                  st_we, valid_clr, cnt_we, cnt_re, out_load;
  logic [CNT_AW-1:0]     cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_inc;
  status_t               ld_status;
  logic [5:0]            ld_bucket;
  logic [31:0]           ld_count;

  assign cmd_in    = cmd_t'(cmd);
  assign accept    = in_valid && in_ready;
  assign slot_idx  = SLOT_AW'(thread_slot);
  assign slot_ok   = int'(thread_slot) < THREAD_SLOTS;
  assign hist_ok   = int'(hist_select) < HISTOGRAMS;
  assign bidx_ok   = int'(bucket_index) < BUCKETS;
  assign valid_hit = start_valid[slot_idx];
  assign clr_done  = clr_addr == CNT_AW'(CNT_DEPTH - 1);
  assign out_free  = !out_valid || out_ready;
  assign cnt_inc   = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;

  llh_log2 u_log2 (
    .clk    (clk),
    .diff   (diff_q),
    .bucket (lg_bucket)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (cmd_in)
            CMD_START: state_next = S_RESULT;
            CMD_END:   state_next = (slot_ok && valid_hit && hist_ok) ? S_DIFF : S_RESULT;
            CMD_READ:  state_next = S_RESULT;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_DIFF:   state_next = S_LZ1;
      S_LZ1:    state_next = S_LZ2;
      S_LZ2:    state_next = S_UPD;
      S_UPD:    if (out_free) state_next = S_IDLE;
      S_RESULT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    st_we     = 1'b0;
    valid_clr = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = clr_addr;
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    cnt_raddr = CNT_AW'(int'(hist_select) * BUCKETS + int'(bucket_index));
    out_load  = 1'b0;
    ld_status = res_status;
    ld_bucket = res_bucket;
    ld_count  = res_use_cnt ? 32'(cnt_rd) : '0;
    case (state)
      S_CLEAR: begin
        cnt_we = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (cmd_in)
            CMD_START: st_we     = slot_ok;
            CMD_END:   valid_clr = slot_ok && valid_hit;
            CMD_READ:  cnt_re    = 1'b1;
            default:   ;
          endcase
        end
      end
      S_LZ2: begin
        cnt_re    = 1'b1;
        cnt_raddr = CNT_AW'(int'(hist_q) * BUCKETS + int'(lg_bucket));
      end
      S_UPD: begin
        ld_status = ST_COUNTED;
        ld_bucket = 6'(bucket_q);
        ld_count  = 32'(cnt_inc);
        if (out_free) begin
          cnt_we    = 1'b1;
          cnt_waddr = upd_addr;
          cnt_wdata = cnt_inc;
          out_load  = 1'b1;
        end
      end
      S_RESULT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
      start_valid <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR && !clr_done) clr_addr <= clr_addr + 1'b1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (st_we) start_valid[slot_idx] <= 1'b1;
      if (valid_clr) start_valid[slot_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ts_q        <= timestamp;
      hist_q      <= hist_select;
      res_bucket  <= (cmd_in == CMD_READ) ? bucket_index : '0;
      res_use_cnt <= (cmd_in == CMD_READ) && hist_ok && bidx_ok;
      case (cmd_in)
        CMD_START: res_status <= ST_START;
        CMD_READ:  res_status <= ST_READ;
        default:   res_status <= ST_IGNORED;
      endcase
    end
    diff_q <= {1'b0, ts_q} - {1'b0, st_rd};
    if (state == S_LZ2) begin
      bucket_q <= lg_bucket;
      upd_addr <= cnt_raddr;
    end
    if (out_load) begin
      status <= ld_status;
      bucket <= ld_bucket;
      count  <= ld_count;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[slot_idx] <= timestamp;
    if (accept) st_rd <= st_mem[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_rd <= cnt_mem[cnt_raddr];
  end

endmodule

[hdl/llh_log2.sv]
// Two-stage floor(log2) encoder for a signed 64-bit duration; differences
// below 2 map to bucket 0, result clamped to the last bucket. Uses llh_pkg.
`timescale 1ns / 1ps
module llh_log2
  import llh_pkg::*;
(
  input  logic                clk,
  input  logic [63:0]         diff,
  output logic [BUCKET_W-1:0] bucket
);

  logic             neg;
  logic [7:0]       grp_nz;
  logic [7:0][2:0]  grp_pos;
  logic [7:0]       grp_nz_next;
  logic [7:0][2:0]  grp_pos_next;
  logic [63:0]      mag;
  logic [5:0]       raw;

  assign mag = {1'b0, diff[62:0]};

  always_comb begin
    grp_nz_next  = '0;
    grp_pos_next = '0;
    for (int g = 0; g < 8; g++) begin
      grp_nz_next[g] = |mag[8*g +: 8];
      for (int k = 0; k < 8; k++) begin
        if (mag[8*g + k]) begin
          grp_pos_next[g] = 3'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    neg     <= diff[63];
    grp_nz  <= grp_nz_next;
    grp_pos <= grp_pos_next;
  end

  always_comb begin
    raw = '0;
    for (int g = 0; g < 8; g++) begin
      if (grp_nz[g]) begin
        raw = {3'(g), grp_pos[g]};
      end
    end
    if (neg) begin
      raw = '0;
    end
  end

  assign bucket = (int'(raw) > BUCKETS - 1) ? BUCKET_W'(BUCKETS - 1) : BUCKET_W'(raw);

endmodule
